// ===== rtl/dsvm_pkg.sv =====
// Shared types and constants for the drum sample voice mixer.
package dsvm_pkg;

    // Field widths of the stream payload
    localparam int VOICE_W    = 3;
    localparam int ADDR_W     = 12;
    localparam int SAMPLE_W   = 16;
    localparam int KEY_W      = 8;
    localparam int OP_W       = 2;
    localparam int COMPARE_W  = 16;
    localparam int MIXED_W    = 3;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PWM_W      = 16;
    localparam int LEN_W      = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP = 3'd0;

    // Mixer constants
    localparam int SILENCE_MID = 32768;
    localparam int MIX_MAX     = 65535;
    localparam logic [KEY_W-1:0] KEY_FIRST = 8'h31;
    localparam logic [KEY_W-1:0] KEY_COUNT = 8'd7;
    localparam logic [SAMPLE_W-1:0] SAMPLE_SIGN = 16'h8000;

    // Operation codes carried in tuser
    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_KEY  = 2'd1,
        OP_TICK = 2'd2
    } op_t;

    // Tick sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/dsvm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dsvm_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
)(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/dsvm_div.sv =====
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
module dsvm_div #(
    parameter int DIVIDEND_W = 20,
    parameter int DIVISOR_W  = 3
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    input  logic        [DIVISOR_W-1:0]  divisor,
    output logic                         done,
    output logic signed [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg,    busy_next;
    logic [STEP_W-1:0]     step_reg,    step_next;
    logic                  neg_reg,     neg_next;
    logic [DIVIDEND_W-1:0] quo_reg,     quo_next;
    logic [DIVISOR_W-1:0]  rem_reg,     rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg,     dsr_next;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  q_bit;

    // one restoring step
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        q_bit   = (shifted >= {1'b0, dsr_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIVIDEND_W);
            neg_next  = dividend[DIVIDEND_W-1];
            quo_next  = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg && step_reg != '0)
        begin
            step_next = step_reg - STEP_W'(1);
            quo_next  = {quo_reg[DIVIDEND_W-2:0], q_bit};
            rem_next  = q_bit ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = busy_reg && (step_reg == '0);
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

// ===== rtl/drum_sample_voice_mixer.sv =====
// Drum sample voice mixer top level; load and key transfers are taken while idle.
// A tick walks the voices one per cycle, then runs the serial divider if any voice was
// active. Ready returns with the result, so no transfer is taken while a tick runs;
// a result the receiver still holds back stalls the emit of the next tick's result.
// Reset clears positions, active flags, lengths to 1 and PWM top to 65535, not the store.
module drum_sample_voice_mixer
    import dsvm_pkg::*;
#(
    parameter int NUM_VOICES   = 7,
    parameter int SAMPLE_DEPTH = 4096
)(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // voice[2:0], word_address[14:3], sample_word[30:15], key_code[38:31], key_pressed[39]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op[1:0]
    input  logic [OP_W-1:0]       s_axis_tuser,
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // compare_value[15:0], voices_mixed[18:16], zero fill [23:19]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int PW        = $clog2(SAMPLE_DEPTH);
    localparam int VW        = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CNT_W     = $clog2(NUM_VOICES + 1);
    localparam int ACC_W     = SAMPLE_W + CNT_W + 1;
    localparam int MEM_DEPTH = NUM_VOICES * SAMPLE_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int CMP_W     = (PW + 1 > LEN_W) ? PW + 1 : LEN_W;
    localparam int PROD_W    = 2 * SAMPLE_W;

    // input field unpacking
    logic [VOICE_W-1:0]  in_voice;
    logic [ADDR_W-1:0]   in_addr;
    logic [SAMPLE_W-1:0] in_sample;
    logic [KEY_W-1:0]    in_key;
    logic                in_pressed;
    logic                in_xfer;

    assign in_voice   = s_axis_tdata[2:0];
    assign in_addr    = s_axis_tdata[14:3];
    assign in_sample  = s_axis_tdata[30:15];
    assign in_key     = s_axis_tdata[38:31];
    assign in_pressed = s_axis_tdata[39];
    assign in_xfer    = s_axis_tvalid && s_axis_tready;

    // state
    state_t                     state_reg,   state_next;
    logic [VW-1:0]              v_reg,       v_next;
    logic [CNT_W-1:0]           cnt_reg,     cnt_next;
    logic                       rd_pend_reg, rd_pend_next;
    logic [PW-1:0]              pos_reg     [NUM_VOICES];
    logic [PW-1:0]              pos_next    [NUM_VOICES];
    logic                       active_reg  [NUM_VOICES];
    logic                       active_next [NUM_VOICES];
    logic [LEN_W-1:0]           len_reg     [NUM_VOICES];
    logic [LEN_W-1:0]           len_next    [NUM_VOICES];
    logic [PWM_W-1:0]           pwm_top_reg, pwm_top_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [ACC_W-1:0]    acc_reg,     acc_next;
    logic [SAMPLE_W-1:0]        samp_reg,    samp_next;
    logic [PROD_W-1:0]          prod_reg,    prod_next;
    logic [COMPARE_W-1:0]       cv_reg,      cv_next;
    logic [MIXED_W-1:0]         vm_reg,      vm_next;

    // decode
    op_t                        in_op;
    logic                       load_ok;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [KEY_W-1:0]           key_off;
    logic                       key_hit;

    // scan
    logic                       scan_act;
    logic [PW-1:0]              scan_pos;
    logic [CMP_W-1:0]           pos_inc;
    logic                       retire;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [SAMPLE_W-1:0]        rd_data;
    logic signed [SAMPLE_W-1:0] smp_s;

    // divide and clamp
    logic                       div_start;
    logic                       div_done;
    logic signed [ACC_W-1:0]    div_quot;
    logic signed [ACC_W:0]      mix_wide;
    logic                       emit_ok;

    // input decode
    always_comb
    begin
        in_op   = op_t'(s_axis_tuser);
        load_ok = (32'(in_voice) < NUM_VOICES) && (32'(in_addr) < SAMPLE_DEPTH);
        wr_addr = AW'(32'(in_voice) * SAMPLE_DEPTH + 32'(in_addr));
        key_off = in_key - KEY_FIRST;
        wr_en   = 1'b0;
        key_hit = 1'b0;
        if (in_xfer)
        begin
            unique case (in_op)
                OP_LOAD:
                begin
                    wr_en = load_ok;
                end
                OP_KEY:
                begin
                    key_hit = in_pressed && (in_key >= KEY_FIRST) && (key_off < KEY_COUNT);
                end
                OP_TICK:
                begin
                    wr_en = 1'b0;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // current voice of the scan
    always_comb
    begin
        scan_act = active_reg[v_reg];
        scan_pos = pos_reg[v_reg];
        pos_inc  = CMP_W'(scan_pos) + CMP_W'(1);
        retire   = (pos_inc >= CMP_W'(len_reg[v_reg])) || (pos_inc >= CMP_W'(SAMPLE_DEPTH));
        rd_en    = (state_reg == ST_SCAN) && scan_act;
        rd_addr  = AW'(32'(v_reg) * SAMPLE_DEPTH + 32'(scan_pos));
        smp_s    = $signed(rd_data ^ SAMPLE_SIGN);
    end

    dsvm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dsvm_div #(
        .DIVIDEND_W (ACC_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign emit_ok = !out_valid_reg || m_axis_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && in_op == OP_TICK)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (v_reg == VW'(NUM_VOICES - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = (cnt_reg == '0) ? ST_MUL : ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        v_next         = v_reg;
        cnt_next       = cnt_reg;
        rd_pend_next   = 1'b0;
        pos_next       = pos_reg;
        active_next    = active_reg;
        len_next       = len_reg;
        pwm_top_next   = pwm_top_reg;
        acc_next       = acc_reg;
        samp_next      = samp_reg;
        prod_next      = prod_reg;
        cv_next        = cv_reg;
        vm_next        = vm_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        div_start      = 1'b0;
        mix_wide       = (ACC_W + 1)'(div_quot) + (ACC_W + 1)'(SILENCE_MID);
        s_axis_tready  = (state_reg == ST_IDLE);

        // configuration writes
        if (cfg_we && cfg_index == CFG_PWM_TOP)
        begin
            pwm_top_next = cfg_data[PWM_W-1:0];
        end
        for (int v = 0; v < NUM_VOICES; v++)
        begin
            if (cfg_we && 32'(cfg_index) == v + 1)
            begin
                len_next[v] = cfg_data[LEN_W-1:0];
            end
        end

        // sample word from the previous scan cycle
        if (rd_pend_reg)
        begin
            acc_next = acc_reg + ACC_W'(smp_s);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                for (int v = 0; v < NUM_VOICES; v++)
                begin
                    if (key_hit && 32'(key_off) == v)
                    begin
                        pos_next[v]    = '0;
                        active_next[v] = 1'b1;
                    end
                end
                if (in_xfer && in_op == OP_TICK)
                begin
                    v_next   = '0;
                    cnt_next = '0;
                    acc_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (scan_act)
                begin
                    rd_pend_next = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                    for (int v = 0; v < NUM_VOICES; v++)
                    begin
                        if (v_reg == VW'(v))
                        begin
                            pos_next[v]    = retire ? '0 : pos_inc[PW-1:0];
                            active_next[v] = !retire;
                        end
                    end
                end
                v_next = v_reg + VW'(1);
            end
            ST_DRAIN:
            begin
                samp_next = SAMPLE_W'(SILENCE_MID);
            end
            ST_DIV_GO:
            begin
                div_start = 1'b1;
            end
            ST_DIV_WAIT:
            begin
                // offset back and clamp to the unsigned sample range
                if (mix_wide < 0)
                begin
                    samp_next = '0;
                end
                else if (mix_wide > (ACC_W + 1)'(MIX_MAX))
                begin
                    samp_next = SAMPLE_W'(MIX_MAX);
                end
                else
                begin
                    samp_next = mix_wide[SAMPLE_W-1:0];
                end
            end
            ST_MUL:
            begin
                prod_next = PROD_W'(samp_reg) * PROD_W'(pwm_top_reg);
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    cv_next        = prod_reg[PROD_W-1:PROD_W-COMPARE_W];
                    vm_next        = MIXED_W'(cnt_reg);
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                v_next = v_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            v_reg         <= '0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            pwm_top_reg   <= PWM_W'(MIX_MAX);
            out_valid_reg <= 1'b0;
            for (int v = 0; v < NUM_VOICES; v++)
            begin
                pos_reg[v]    <= '0;
                active_reg[v] <= 1'b0;
                len_reg[v]    <= LEN_W'(1);
            end
        end
        else
        begin
            state_reg     <= state_next;
            v_reg         <= v_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            pwm_top_reg   <= pwm_top_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            active_reg    <= active_next;
            len_reg       <= len_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        samp_reg <= samp_next;
        prod_reg <= prod_next;
        cv_reg   <= cv_next;
        vm_reg   <= vm_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - COMPARE_W - MIXED_W)'(0), vm_reg, cv_reg};

endmodule
